### src/strot_pkg.sv
package strot_pkg;

    // Longest string each buffer holds.
    localparam int MAX_LEN = 16;

    // Index into a buffer, and a length that can also hold MAX_LEN itself.
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // Field widths of the two channels.
    localparam int MODE_W  = 2;
    localparam int CH_W    = 8;
    localparam int SHIFT_W = 4;

    // Item codes carried in the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_FIRST  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_END    = 2'd2
    } t_mode;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

### src/strot_if.sv
interface strot_in_if;
    import strot_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   ch;

    modport source (output valid, output mode, output ch, input ready);
    modport sink (input valid, input mode, input ch, output ready);
endinterface

interface strot_out_if;
    import strot_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_rotation;
    logic [SHIFT_W-1:0] shift;
    logic               overflow;

    modport source (output valid, output is_rotation, output shift, output overflow,
                    input ready);
    modport sink (input valid, input is_rotation, input shift, input overflow,
                  output ready);
endinterface

### src/strot_ram.sv
module strot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/string_rotation_check.sv
// Channel  Dir  Payload                          Beat moves
// i_in     in   mode[1:0], ch[7:0]               one load or end item
// o_out    out  is_rotation, shift[3:0], overflow one check result
//
// Load beats are taken back to back while the sequencer is idle.
// An end beat on equal, nonempty strings with no overflow runs a search over
// rotations k and positions i through one byte comparator fed by the two buffer
// RAMs: each compare reads in ST_READ and compares in ST_CMP, smallest k first.
// Reset clears lengths, overflow and the sequencer; buffer contents are not cleared.
// A result waits in the output register; loads are still taken while it waits.
module string_rotation_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    strot_in_if.sink    i_in,
    strot_out_if.source o_out
);
    import strot_pkg::*;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_first_len, n_first_len;
    logic [LEN_W-1:0]   r_second_len, n_second_len;
    logic               r_ovf_flag, n_ovf_flag;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic               r_res_rot, n_res_rot;
    logic [SHIFT_W-1:0] r_res_shift, n_res_shift;
    logic               r_out_valid, n_out_valid;
    logic               r_out_rot;
    logic [SHIFT_W-1:0] r_out_shift;
    logic               r_out_ovf;

    logic               accept;
    logic               out_load;
    logic               we_first, we_second;
    logic [CH_W-1:0]    q_first, q_second;
    logic [LEN_W-1:0]   k_next, i_next, j_next;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Result register frees when empty or when the sink takes the beat.
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    assign k_next = LEN_W'(r_k) + LEN_W'(1);
    assign i_next = LEN_W'(r_i) + LEN_W'(1);
    assign j_next = LEN_W'(r_j) + LEN_W'(1);

    // Buffer writes on load beats into a string that still has room.
    assign we_first  = accept && (i_in.mode == MODE_FIRST) &&
                       (r_first_len < LEN_W'(MAX_LEN));
    assign we_second = accept && (i_in.mode == MODE_SECOND) &&
                       (r_second_len < LEN_W'(MAX_LEN));

    strot_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (we_first),
        .i_waddr (r_first_len[IDX_W-1:0]),
        .i_wdata (i_in.ch),
        .i_raddr (r_j),
        .o_rdata (q_first)
    );

    strot_ram #(.WIDTH(CH_W), .DEPTH(MAX_LEN)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (we_second),
        .i_waddr (r_second_len[IDX_W-1:0]),
        .i_wdata (i_in.ch),
        .i_raddr (r_i),
        .o_rdata (q_second)
    );

    // Sequencer: loads, then the rotation search, then the result hand-off.
    always_comb begin
        n_state      = r_state;
        n_first_len  = r_first_len;
        n_second_len = r_second_len;
        n_ovf_flag   = r_ovf_flag;
        n_k          = r_k;
        n_i          = r_i;
        n_j          = r_j;
        n_res_rot    = r_res_rot;
        n_res_shift  = r_res_shift;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.mode)
                        MODE_FIRST: begin
                            if (we_first) begin
                                n_first_len = r_first_len + LEN_W'(1);
                            end else begin
                                n_ovf_flag = 1'b1;
                            end
                        end
                        MODE_SECOND: begin
                            if (we_second) begin
                                n_second_len = r_second_len + LEN_W'(1);
                            end else begin
                                n_ovf_flag = 1'b1;
                            end
                        end
                        MODE_END: begin
                            n_k         = '0;
                            n_i         = '0;
                            n_j         = '0;
                            n_res_shift = '0;
                            if (r_ovf_flag || (r_first_len != r_second_len)) begin
                                n_res_rot = 1'b0;
                                n_state   = ST_DONE;
                            end else if (r_first_len == '0) begin
                                n_res_rot = 1'b1;
                                n_state   = ST_DONE;
                            end else begin
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            // The unused code leaves everything as it is.
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (q_first == q_second) begin
                    if (i_next == r_first_len) begin
                        n_res_rot   = 1'b1;
                        n_res_shift = SHIFT_W'(r_k);
                        n_state     = ST_DONE;
                    end else begin
                        n_i     = IDX_W'(i_next);
                        n_j     = (j_next == r_first_len) ? '0 : IDX_W'(j_next);
                        n_state = ST_READ;
                    end
                end else begin
                    if (k_next == r_first_len) begin
                        n_res_rot = 1'b0;
                        n_state   = ST_DONE;
                    end else begin
                        n_k     = IDX_W'(k_next);
                        n_i     = '0;
                        n_j     = IDX_W'(k_next);
                        n_state = ST_READ;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_first_len  = '0;
                    n_second_len = '0;
                    n_ovf_flag   = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid tracking.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_first_len  <= '0;
            r_second_len <= '0;
            r_ovf_flag   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_len  <= n_first_len;
            r_second_len <= n_second_len;
            r_ovf_flag   <= n_ovf_flag;
            r_out_valid  <= n_out_valid;
        end
    end

    // Search counters and result payload.
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_i         <= n_i;
        r_j         <= n_j;
        r_res_rot   <= n_res_rot;
        r_res_shift <= n_res_shift;
        if (out_load) begin
            r_out_rot   <= r_res_rot;
            r_out_shift <= r_res_shift;
            r_out_ovf   <= r_ovf_flag;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.is_rotation = r_out_rot;
    assign o_out.shift       = r_out_shift;
    assign o_out.overflow    = r_out_ovf;

    // A string that overflowed never reports a rotation.
    a_no_rot_on_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.is_rotation && o_out.overflow))
        else $error("rotation reported together with overflow");

    // A negative result always carries a zero shift.
    a_shift_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_rotation) |-> (o_out.shift == '0))
        else $error("nonzero shift on a negative result");

    // The rotation under test stays below the string length.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (LEN_W'(r_k) < r_first_len))
        else $error("rotation index out of range");

    // A pending result that is not taken holds the sequencer in its hand-off.
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_out.ready) |=> (r_state == ST_DONE))
        else $error("result overwritten while still pending");

    // An end beat closes the input until its result is produced.
    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.mode == MODE_END) |=> !i_in.ready)
        else $error("input open right after an end beat");

endmodule

### tb/sv/tb_string_rotation_check.sv
`timescale 1ns / 1ps

module tb_string_rotation_check;
    import strot_pkg::*;

    // Mode code that the block must ignore.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Load and end beats to generate at least, directed part included.
    localparam int unsigned N_ITEMS = 1425;
    // Once this few beats remain, neither side idles any more.
    localparam int unsigned QUIET_TAIL = 150;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CH_W-1:0]   ch;
        logic              hold;
    } t_beat;

    typedef struct packed {
        logic               is_rotation;
        logic [SHIFT_W-1:0] shift;
        logic               overflow;
    } t_verdict;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              drv_valid  = 1'b0;
    logic [MODE_W-1:0] drv_mode   = MODE_FIRST;
    logic [CH_W-1:0]   drv_ch     = '0;
    logic              sink_ready = 1'b0;

    strot_in_if  in_if ();
    strot_out_if out_if ();

    assign in_if.valid  = drv_valid;
    assign in_if.mode   = drv_mode;
    assign in_if.ch     = drv_ch;
    assign out_if.ready = sink_ready;

    string_rotation_check dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the two string buffers and the verdicts still owed by the block.
    logic [CH_W-1:0]  first_str [MAX_LEN];
    logic [CH_W-1:0]  second_str [MAX_LEN];
    logic [LEN_W-1:0] first_len  = '0;
    logic [LEN_W-1:0] second_len = '0;
    logic             too_long   = 1'b0;
    t_verdict         verdicts [$];

    t_beat           pending [$];
    int unsigned     n_items    = 0;
    int unsigned     mismatches = 0;
    logic [CH_W-1:0] str_a [$];
    logic [CH_W-1:0] str_b [$];

    // Applies one accepted beat to the mirrored state; an end beat yields a verdict.
    function automatic void fold_beat(input t_beat b);
        t_verdict v;
        int       n;
        int       k;
        int       i;
        bit       same;
        case (b.mode)
            MODE_FIRST: begin
                if (first_len < MAX_LEN) begin
                    first_str[first_len[IDX_W-1:0]] = b.ch;
                    first_len++;
                end else begin
                    too_long = 1'b1;
                end
            end
            MODE_SECOND: begin
                if (second_len < MAX_LEN) begin
                    second_str[second_len[IDX_W-1:0]] = b.ch;
                    second_len++;
                end else begin
                    too_long = 1'b1;
                end
            end
            MODE_END: begin
                v = '0;
                v.overflow = too_long;
                n = int'(first_len);
                if (!too_long && first_len == second_len) begin
                    if (n == 0)
                        v.is_rotation = 1'b1;
                    // Try each left shift, smallest first, until one lines up.
                    for (k = 0; k < n && !v.is_rotation; k++) begin
                        same = 1'b1;
                        for (i = 0; i < n; i++)
                            if (first_str[(k + i) % n] != second_str[i])
                                same = 1'b0;
                        if (same) begin
                            v.is_rotation = 1'b1;
                            v.shift = SHIFT_W'(k);
                        end
                    end
                end
                verdicts.push_back(v);
                first_len  = '0;
                second_len = '0;
                too_long   = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_beat(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] ch,
                                     input logic hold);
        t_beat b;
        b.mode = mode;
        b.ch   = ch;
        b.hold = hold;
        pending.push_back(b);
        if (mode != MODE_UNUSED)
            n_items++;
    endfunction

    // Queues the loads of str_a and str_b, then the end beat. With mixed set the loads
    // of the two strings are interleaved. Hold goes on the first beat only.
    function automatic void add_pair(input bit mixed, input logic hold);
        int ia;
        int ib;
        bit take_a;
        ia = 0;
        ib = 0;
        while (ia < str_a.size() || ib < str_b.size()) begin
            if (ia >= str_a.size())
                take_a = 1'b0;
            else if (ib >= str_b.size())
                take_a = 1'b1;
            else
                take_a = mixed ? 1'($urandom_range(0, 1)) : 1'b1;
            if (take_a) begin
                add_beat(MODE_FIRST, str_a[ia], hold);
                ia++;
            end else begin
                add_beat(MODE_SECOND, str_b[ib], hold);
                ib++;
            end
            hold = 1'b0;
        end
        add_beat(MODE_END, CH_W'($urandom), hold);
    endfunction

    // Builds a random pair from a two-letter alphabet with stray bytes, so that periodic
    // strings and repeated letters are common. The second string is mostly a rotation
    // of the first; the rest are near misses, fresh text, other lengths or too long.
    function automatic void add_random_pair(input logic hold);
        int              len_a;
        int              k;
        int              i;
        int              pick;
        int              j;
        logic [CH_W-1:0] sym0;
        logic [CH_W-1:0] sym1;
        logic [CH_W-1:0] c;
        sym0 = CH_W'($urandom);
        sym1 = CH_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len_a = $urandom_range(0, 6);
        else if (pick < 94)
            len_a = $urandom_range(7, MAX_LEN);
        else
            len_a = $urandom_range(MAX_LEN + 1, MAX_LEN + 2);
        str_a.delete();
        str_b.delete();
        for (i = 0; i < len_a; i++) begin
            if ($urandom_range(0, 3) == 0)
                c = CH_W'($urandom);
            else
                c = $urandom_range(0, 1) ? sym1 : sym0;
            str_a.push_back(c);
        end
        k = (len_a > 0) ? $urandom_range(0, len_a - 1) : 0;
        for (i = 0; i < len_a; i++)
            str_b.push_back(str_a[(k + i) % len_a]);
        pick = $urandom_range(0, 99);
        if (pick >= 55 && pick < 70 && len_a > 0) begin
            j = $urandom_range(0, len_a - 1);
            str_b[j] = str_b[j] ^ (CH_W'(1) << $urandom_range(0, CH_W - 1));
        end else if (pick >= 70 && pick < 82) begin
            for (i = 0; i < str_b.size(); i++)
                str_b[i] = $urandom_range(0, 1) ? sym1 : sym0;
        end else if (pick >= 82 && pick < 90) begin
            if (len_a > 0 && $urandom_range(0, 1) == 1)
                void'(str_b.pop_back());
            else
                str_b.push_back(sym0);
        end else if (pick >= 90 && len_a <= MAX_LEN) begin
            while (str_b.size() <= MAX_LEN)
                str_b.push_back(sym1);
        end
        add_pair($urandom_range(0, 4) == 0, hold);
    endfunction

    // Stimulus, reset and the end of the run.
    initial begin
        int unsigned n_pairs;
        int          i;
        n_pairs = 0;

        // Two empty strings are a rotation of each other.
        str_a.delete();
        str_b.delete();
        add_pair(1'b0, 1'b0);
        // The unused mode code must leave no trace.
        add_beat(MODE_UNUSED, 8'hFF, 1'b0);
        // All-zero and all-one bytes, one shift apart.
        str_a.push_back(8'h00);
        str_a.push_back(8'hFF);
        str_b.push_back(8'hFF);
        str_b.push_back(8'h00);
        add_pair(1'b0, 1'b0);
        // First string one character too long; wait for the block to go idle first.
        str_a.delete();
        str_b.delete();
        for (i = 0; i <= MAX_LEN; i++)
            str_a.push_back(CH_W'(8'hA5 + i));
        add_pair(1'b0, 1'b1);

        // Random pairs with some ignored beats as noise.
        while (n_items < N_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                add_beat(MODE_UNUSED, CH_W'($urandom), 1'b0);
            end else begin
                add_random_pair(n_pairs % 25 == 24);
                n_pairs++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending.size() == 0);
        wait (verdicts.size() == 0);
        // Watch for stray results after the last verdict.
        repeat (600) @(posedge clk);
        if (mismatches == 0 && verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    int unsigned drv_gap   = 0;
    int unsigned ends_open = 0;
    bit          drv_calm  = 1'b0;
    bit          in_tail   = 1'b0;

    // Driver: presents the oldest pending beat and folds each accepted one into the mirror.
    always @(posedge clk) begin
        t_beat b;
        bit    accepted;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            accepted = drv_valid && in_if.ready;
            in_tail <= (pending.size() <= QUIET_TAIL);
            // Ends the block still owes a result for, counted from the wires alone.
            if (out_if.valid && out_if.ready && ends_open > 0)
                ends_open--;
            if (accepted) begin
                b = pending.pop_front();
                fold_beat(b);
                if (b.mode == MODE_END)
                    ends_open++;
                if (!drv_calm && !in_tail && $urandom_range(0, 3) == 0)
                    drv_gap = $urandom_range(1, 16);
            end
            if ($urandom_range(0, 199) == 0)
                drv_calm = !drv_calm;
            // A beat on the wires stays there until it is taken.
            if (!drv_valid || accepted) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    drv_valid <= 1'b0;
                end else if (pending.size() > 0 && (!pending[0].hold || ends_open == 0)) begin
                    drv_valid <= 1'b1;
                    drv_mode  <= pending[0].mode;
                    drv_ch    <= pending[0].ch;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    int unsigned sink_stall = 0;
    bit          sink_calm  = 1'b0;

    // Monitor: checks each result beat against the oldest verdict and stalls at random.
    always @(posedge clk) begin
        t_verdict want;
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_if.valid && sink_ready) begin
                if (verdicts.size() == 0) begin
                    $error("result beat with no end beat outstanding");
                    mismatches++;
                end else begin
                    want = verdicts.pop_front();
                    if (out_if.is_rotation !== want.is_rotation) begin
                        $error("is_rotation: expected %0d, got %0d",
                               want.is_rotation, out_if.is_rotation);
                        mismatches++;
                    end
                    if (out_if.shift !== want.shift) begin
                        $error("shift: expected %0d, got %0d", want.shift, out_if.shift);
                        mismatches++;
                    end
                    if (out_if.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d",
                               want.overflow, out_if.overflow);
                        mismatches++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0)
                sink_calm = !sink_calm;
            if (sink_stall > 0) begin
                sink_stall--;
                sink_ready <= 1'b0;
            end else if (!sink_calm && !in_tail && $urandom_range(0, 11) == 0) begin
                sink_stall = $urandom_range(0, 15);
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

endmodule

### sim.f
src/strot_pkg.sv
src/strot_if.sv
src/strot_ram.sv
src/string_rotation_check.sv
tb/sv/tb_string_rotation_check.sv
